// ===== sv/sff_pkg.sv =====
// shared types, codes and constants for the sysex firmware framer
// no dependencies; used by sff_ctrl, sff_dpath and sysex_firmware_framer
`default_nettype none

package sff_pkg;

    // data bytes per sysex message (default), chunk counter width
    localparam int CHUNK_BYTES_DEF = 32;
    localparam int CHUNK_W         = 5;

    // request command codes
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_DATA   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_TARGET_UID = 2'd0;
    localparam logic [1:0] REG_START_WORD = 2'd1;
    localparam logic [1:0] REG_END_WORD   = 2'd2;

    // output byte sources
    localparam logic [1:0] SRC_HDR  = 2'd0;
    localparam logic [1:0] SRC_WORD = 2'd1;
    localparam logic [1:0] SRC_DATA = 2'd2;
    localparam logic [1:0] SRC_EOM  = 2'd3;

    // word selects for command / length messages
    localparam logic [2:0] WSEL_START_LO = 3'd0;
    localparam logic [2:0] WSEL_START_HI = 3'd1;
    localparam logic [2:0] WSEL_LEN      = 3'd2;
    localparam logic [2:0] WSEL_END_LO   = 3'd3;
    localparam logic [2:0] WSEL_END_HI   = 3'd4;

    // sysex framing and payload constants
    localparam logic [7:0] SYSEX_SOM = 8'hF0;
    localparam logic [7:0] SYSEX_EOM = 8'hF7;
    localparam logic [7:0] MFR_ID0   = 8'h00;
    localparam logic [7:0] MFR_ID1   = 8'h53;
    localparam logic [7:0] MFR_ID2   = 8'h43;
    localparam logic [7:0] LOW7_MASK = 8'h7F;
    localparam logic [7:0] PAD_BYTE  = 8'hFF;

    // controller to datapath
    typedef struct packed {
        logic       emit;   // push a byte into the output register
        logic [1:0] src;
        logic [2:0] wsel;
        logic [2:0] idx;    // byte of the selected word, or header position
        logic       half;   // 0: bit 7, 1: low 7 bits
        logic       last;
        logic       pad;    // data byte is the pad value
        logic       load;   // capture request payload
        logic       clear;  // clear framing state
        logic       step;   // one data byte sent
        logic       close;  // data message closed
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic msg_open;
        logic quad_zero;
        logic chunk_full;
    } dp_stat_t;

    function automatic logic [7:0] header_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = SYSEX_SOM;
            2'd1:    b = MFR_ID0;
            2'd2:    b = MFR_ID1;
            default: b = MFR_ID2;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sff_ctrl.sv =====
// framing sequencer: walks header, payload, data, end-of-message and finish steps
// depends on sff_pkg
`default_nettype none

module sff_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire logic [1:0]      command,
    input  wire sff_pkg::dp_stat_t stat,
    output sff_pkg::ctl_cmd_t    cmd
);
    import sff_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_BODY = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_EOM  = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [1:0] job_reg, job_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       half_reg, half_next;
    logic [1:0] msg_reg, msg_next;
    logic       tail_reg, tail_next;

    logic       word_mode;
    logic [2:0] body_last;
    logic [2:0] wsel;

    assign item_stall = (state_reg != ST_IDLE);

    // start and end-command messages carry words, the rest carry data bytes
    assign word_mode = (job_reg == CMD_START) || tail_reg;

    always_comb
    begin
        if (job_reg == CMD_START)
        begin
            if (msg_reg == 2'd0)
                wsel = WSEL_START_LO;
            else if (msg_reg == 2'd1)
                wsel = WSEL_START_HI;
            else
                wsel = WSEL_LEN;
        end
        else
        begin
            wsel = msg_reg[0] ? WSEL_END_HI : WSEL_END_LO;
        end
    end

    always_comb
    begin
        if (job_reg == CMD_START)
            body_last = (msg_reg == 2'd2) ? 3'd7 : 3'd3;
        else
            body_last = 3'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        half_next  = half_reg;
        msg_next   = msg_reg;
        tail_next  = tail_reg;

        cmd       = '0;
        cmd.idx   = cnt_reg;
        cmd.half  = half_reg;
        cmd.wsel  = wsel;
        cmd.pad   = (job_reg != CMD_DATA);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load  = 1'b1;
                    job_next  = command;
                    cnt_next  = 3'd0;
                    half_next = 1'b0;
                    msg_next  = 2'd0;
                    tail_next = 1'b0;
                    unique case (command)
                        CMD_START:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = ST_HDR;
                        end
                        CMD_DATA:
                            state_next = stat.msg_open ? ST_DATA : ST_HDR;
                        CMD_FINISH:
                            state_next = ST_FIN;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end

            ST_HDR:
            begin
                cmd.src  = SRC_HDR;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    if (cnt_reg == 3'd3)
                    begin
                        cnt_next   = 3'd0;
                        half_next  = 1'b0;
                        state_next = word_mode ? ST_BODY : ST_DATA;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
            end

            ST_BODY:
            begin
                cmd.src  = SRC_WORD;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    if (half_reg)
                    begin
                        half_next = 1'b0;
                        if (cnt_reg == body_last)
                        begin
                            cnt_next   = 3'd0;
                            state_next = ST_EOM;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        half_next = 1'b1;
                    end
                end
            end

            ST_DATA:
            begin
                cmd.src  = SRC_DATA;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    if (!half_reg)
                    begin
                        half_next = 1'b1;
                    end
                    else
                    begin
                        half_next = 1'b0;
                        cmd.step  = 1'b1;
                        if (stat.chunk_full)
                        begin
                            state_next = ST_EOM;
                        end
                        else if (job_reg == CMD_DATA)
                        begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end

            ST_EOM:
            begin
                cmd.src  = SRC_EOM;
                cmd.emit = stat.out_free;
                if (stat.out_free)
                begin
                    priority if (job_reg == CMD_START)
                    begin
                        if (msg_reg == 2'd2)
                        begin
                            cmd.last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            msg_next   = msg_reg + 2'd1;
                            state_next = ST_HDR;
                        end
                    end
                    else if (job_reg == CMD_DATA)
                    begin
                        cmd.close  = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (!tail_reg)
                    begin
                        cmd.close  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (msg_reg == 2'd1)
                    begin
                        cmd.clear  = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        msg_next   = msg_reg + 2'd1;
                        state_next = ST_HDR;
                    end
                end
            end

            ST_FIN:
            begin
                // pad to a 4-byte boundary, close any open message, then end words
                cnt_next  = 3'd0;
                half_next = 1'b0;
                priority if (!stat.quad_zero)
                begin
                    state_next = stat.msg_open ? ST_DATA : ST_HDR;
                end
                else if (stat.msg_open)
                begin
                    state_next = ST_EOM;
                end
                else
                begin
                    tail_next  = 1'b1;
                    msg_next   = 2'd0;
                    state_next = ST_HDR;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= CMD_START;
            cnt_reg   <= 3'd0;
            half_reg  <= 1'b0;
            msg_reg   <= 2'd0;
            tail_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
            half_reg  <= half_next;
            msg_reg   <= msg_next;
            tail_reg  <= tail_next;
        end
    end

    // the final byte of a request always returns the sequencer to idle
    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit && cmd.last |=> state_reg == ST_IDLE)
        else $error("sequencer not idle after last byte");

    // the pad/close decision step only serves a finish request
    a_fin_job: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> job_reg == CMD_FINISH)
        else $error("finish step outside a finish request");

endmodule

`default_nettype wire

// ===== sv/sff_dpath.sv =====
// datapath: config registers, request capture, framing counters, byte mux,
// output register; depends on sff_pkg
`default_nettype none

module sff_dpath #(
    parameter int CHUNK_BYTES = sff_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    input  wire logic [7:0]      data_byte,
    input  wire logic [31:0]     image_length,
    input  wire sff_pkg::ctl_cmd_t cmd,
    output sff_pkg::dp_stat_t    stat,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output logic [7:0]           out_byte,
    output logic                 run_last
);
    import sff_pkg::*;

    logic [31:0]        target_uid_reg;
    logic [63:0]        start_word_reg;
    logic [31:0]        end_word_reg;

    logic [7:0]         data_reg;
    logic [31:0]        padded_reg;

    logic [CHUNK_W-1:0] chunk_count_reg;
    logic               message_open_reg;
    logic [1:0]         quad_phase_reg;

    logic               result_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               run_last_reg;

    logic               out_free;
    logic               chunk_full;
    logic [63:0]        word;
    logic [7:0]         word_byte;
    logic [7:0]         pay_byte;
    logic [7:0]         split_byte;
    logic [7:0]         byte_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_uid_reg <= '0;
            start_word_reg <= '0;
            end_word_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TARGET_UID)
                target_uid_reg <= cfg_data[31:0];
            if (cfg_index == REG_START_WORD)
                start_word_reg <= cfg_data;
            if (cfg_index == REG_END_WORD)
                end_word_reg <= cfg_data[31:0];
        end
    end

    // request payload, length rounded up to a multiple of 4
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            data_reg   <= data_byte;
            padded_reg <= (image_length + 32'd3) & ~32'd3;
        end
    end

    assign chunk_full = (chunk_count_reg == CHUNK_W'(CHUNK_BYTES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_count_reg  <= '0;
            message_open_reg <= 1'b0;
            quad_phase_reg   <= 2'd0;
        end
        else if (cmd.clear)
        begin
            chunk_count_reg  <= '0;
            message_open_reg <= 1'b0;
            quad_phase_reg   <= 2'd0;
        end
        else if (cmd.step)
        begin
            chunk_count_reg  <= chunk_full ? '0 : chunk_count_reg + CHUNK_W'(1);
            message_open_reg <= !chunk_full;
            quad_phase_reg   <= quad_phase_reg + 2'd1;
        end
        else if (cmd.close)
        begin
            chunk_count_reg  <= '0;
            message_open_reg <= 1'b0;
        end
    end

    always_comb
    begin
        unique case (cmd.wsel)
            WSEL_START_LO: word = {32'd0, start_word_reg[31:0]};
            WSEL_START_HI: word = {32'd0, start_word_reg[63:32]};
            WSEL_LEN:      word = {target_uid_reg, padded_reg};
            WSEL_END_LO:   word = {48'd0, end_word_reg[15:0]};
            WSEL_END_HI:   word = {48'd0, end_word_reg[31:16]};
            default:       word = '0;
        endcase
    end

    assign word_byte  = word[{cmd.idx, 3'b000} +: 8];
    assign pay_byte   = (cmd.src == SRC_DATA) ? (cmd.pad ? PAD_BYTE : data_reg) : word_byte;
    assign split_byte = cmd.half ? (pay_byte & LOW7_MASK) : {7'd0, pay_byte[7]};

    always_comb
    begin
        unique case (cmd.src)
            SRC_HDR:  byte_next = header_byte(cmd.idx[1:0]);
            SRC_WORD: byte_next = split_byte;
            SRC_DATA: byte_next = split_byte;
            default:  byte_next = SYSEX_EOM;
        endcase
    end

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (out_free)
            result_valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && cmd.emit)
        begin
            out_byte_reg <= byte_next;
            run_last_reg <= cmd.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;

    assign stat.out_free   = out_free;
    assign stat.msg_open   = message_open_reg;
    assign stat.quad_zero  = (quad_phase_reg == 2'd0);
    assign stat.chunk_full = chunk_full;

    // a closed message never leaves a partial chunk count behind
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !message_open_reg |-> chunk_count_reg == '0)
        else $error("chunk count set with no open message");

    // the chunk counter wraps before reaching the message size
    a_chunk_range: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_count_reg <= CHUNK_W'(CHUNK_BYTES - 1))
        else $error("chunk count beyond message size");

    // no byte is pushed while the output register holds a stalled byte
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_stall |-> !(cmd.emit && out_free))
        else $error("output byte overwritten while stalled");

endmodule

`default_nettype wire

// ===== sv/sysex_firmware_framer.sv =====
// top level of the sysex firmware framer: sequencer plus datapath
// depends on sff_pkg, sff_ctrl, sff_dpath
//
//  channel   signals                                   handshake
//  --------  ----------------------------------------  ------------------------
//  request   command, data_byte, image_length          item_valid / item_stall
//  result    out_byte, run_last                        result_valid / result_stall
//  config    cfg_index, cfg_data                       cfg_valid / cfg_ready
//
//  one request at a time: item_stall stays high until its last byte is pushed
//  a data byte goes out as bit 7 then low 7 bits, after a header if it opens a
//  message, and ends it with end-of-message if it fills one; start sends three
//  word messages; finish pads, closes and sends end words; others emit nothing
//  result_stall holds the sequencer while the single output register is full
//  rst_n clears config registers, framing state and the output register
`default_nettype none

module sysex_firmware_framer #(
    parameter int CHUNK_BYTES = sff_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  data_byte,
    input  wire logic [31:0] image_length,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import sff_pkg::*;

    // command and status between sequencer and datapath
    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    // sequencer: accepts a request when idle and steps through its bytes
    sff_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .command    (command),
        .stat       (dp_stat),
        .cmd        (ctl_cmd)
    );

    // datapath: registers, counters, byte selection and output register
    sff_dpath #(
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_byte    (data_byte),
        .image_length (image_length),
        .cmd          (ctl_cmd),
        .stat         (dp_stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire
